FILE: design/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the text encoding sniffer
// Verdict codes, byte-order-mark bytes, UTF-8 class masks and the item type.
// ----------------------------------------------------------------------------
package tes_pkg;

  typedef enum logic [2:0] {
    KIND_ASCII   = 3'd0,
    KIND_UTF8    = 3'd1,
    KIND_UTF16BE = 3'd2,
    KIND_UTF16LE = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  // byte-order-mark bytes
  localparam logic [7:0] BOM8_B0  = 8'hEF;
  localparam logic [7:0] BOM8_B1  = 8'hBB;
  localparam logic [7:0] BOM8_B2  = 8'hBF;
  localparam logic [7:0] BOM16_FE = 8'hFE;
  localparam logic [7:0] BOM16_FF = 8'hFF;

  // UTF-8 byte classes
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  // candidate bits for the byte-order marks
  localparam int CAND_UTF8 = 0;
  localparam int CAND_BE   = 1;
  localparam int CAND_LE   = 2;
  localparam logic [2:0] CAND_ALL = 3'b111;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  // held item towards the classifier, with its valid flag
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic  push;
    kind_t kind;
  } result_t;

endpackage

FILE: design/tes_if.sv
// ----------------------------------------------------------------------------
// tes_in_if / tes_out_if: valid-ready channels of the sniffer
// One byte item in, one verdict out.
// ----------------------------------------------------------------------------
interface tes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output data_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface tes_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding_kind;

  modport source (output valid, output encoding_kind, input ready);
  modport sink   (input valid, input encoding_kind, output ready);
endinterface

FILE: design/tes_in_stage.sv
// ----------------------------------------------------------------------------
// tes_in_stage: input register
// Holds one byte beat until the classifier takes it.
// ----------------------------------------------------------------------------
module tes_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  tes_in_if.sink          in_ch,
  input  logic            take,
  output tes_pkg::stage_t stage
);
  import tes_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  // free when empty or emptied this cycle
  assign in_ch.ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.valid && in_ch.ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.data_byte      <= in_ch.data_byte;
      item_r.byte_present   <= in_ch.byte_present;
      item_r.end_of_message <= in_ch.end_of_message;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

FILE: design/tes_classify.sv
// ----------------------------------------------------------------------------
// tes_classify: per-message mark tracking, UTF-8 check and verdict
// Updates the message state from the held byte and forms the verdict.
// ----------------------------------------------------------------------------
module tes_classify (
  input  logic             clk,
  input  logic             rst_n,
  input  tes_pkg::stage_t  stage,
  input  logic             out_space,
  output logic             take,
  output tes_pkg::result_t result
);
  import tes_pkg::*;

  logic [1:0] pos_r, pos_nxt;
  logic [2:0] cand_r, cand_nxt;
  logic [1:0] pend_r, pend_nxt;
  logic       nonascii_r, nonascii_nxt;
  logic       err_r, err_nxt;

  logic [1:0] pos_u;
  logic [2:0] cand_u;
  logic [1:0] pend_u;
  logic       nonascii_u, err_u;
  logic [7:0] b;
  kind_t      kind;

  // a closing beat needs room for its verdict
  assign take = stage.valid && (!stage.item.end_of_message || out_space);
  assign b    = stage.item.data_byte;

  always_comb begin
    pos_u      = pos_r;
    cand_u     = cand_r;
    pend_u     = pend_r;
    nonascii_u = nonascii_r;
    err_u      = err_r;
    if (stage.item.byte_present) begin
      unique case (pos_r)
        2'd0: begin
          if (b != BOM8_B0)  cand_u[CAND_UTF8] = 1'b0;
          if (b != BOM16_FE) cand_u[CAND_BE]   = 1'b0;
          if (b != BOM16_FF) cand_u[CAND_LE]   = 1'b0;
        end
        2'd1: begin
          if (b != BOM8_B1)  cand_u[CAND_UTF8] = 1'b0;
          if (b != BOM16_FF) cand_u[CAND_BE]   = 1'b0;
          if (b != BOM16_FE) cand_u[CAND_LE]   = 1'b0;
        end
        2'd2: begin
          if (b != BOM8_B2)  cand_u[CAND_UTF8] = 1'b0;
        end
        default: ;
      endcase
      if (pos_r != 2'd3) pos_u = pos_r + 2'd1;

      // sticky error freezes the UTF-8 state
      if (!err_r) begin
        if (pend_r != 2'd0) begin
          if ((b & CONT_MASK) != CONT_CODE) err_u = 1'b1;
          else pend_u = pend_r - 2'd1;
        end else if (b > ASCII_MAX) begin
          nonascii_u = 1'b1;
          priority if ((b & LEAD2_MASK) == LEAD2_CODE) pend_u = 2'd1;
          else if ((b & LEAD3_MASK) == LEAD3_CODE)     pend_u = 2'd2;
          else if ((b & LEAD4_MASK) == LEAD4_CODE)     pend_u = 2'd3;
          else                                         err_u  = 1'b1;
        end
      end
    end
  end

  always_comb begin
    priority if (cand_u[CAND_UTF8] && pos_u == 2'd3)    kind = KIND_UTF8;
    else if (pos_u[1] && cand_u[CAND_BE])               kind = KIND_UTF16BE;
    else if (pos_u[1] && cand_u[CAND_LE])               kind = KIND_UTF16LE;
    else if (err_u || pend_u != 2'd0)                   kind = KIND_UNKNOWN;
    else if (nonascii_u)                                kind = KIND_UTF8;
    else                                                kind = KIND_ASCII;
  end

  always_comb begin
    pos_nxt      = pos_r;
    cand_nxt     = cand_r;
    pend_nxt     = pend_r;
    nonascii_nxt = nonascii_r;
    err_nxt      = err_r;
    if (take) begin
      if (stage.item.end_of_message) begin
        pos_nxt      = 2'd0;
        cand_nxt     = CAND_ALL;
        pend_nxt     = 2'd0;
        nonascii_nxt = 1'b0;
        err_nxt      = 1'b0;
      end else begin
        pos_nxt      = pos_u;
        cand_nxt     = cand_u;
        pend_nxt     = pend_u;
        nonascii_nxt = nonascii_u;
        err_nxt      = err_u;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 2'd0;
      cand_r     <= CAND_ALL;
      pend_r     <= 2'd0;
      nonascii_r <= 1'b0;
      err_r      <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      cand_r     <= cand_nxt;
      pend_r     <= pend_nxt;
      nonascii_r <= nonascii_nxt;
      err_r      <= err_nxt;
    end
  end

  assign result.push = take && stage.item.end_of_message;
  assign result.kind = kind;

endmodule

FILE: design/tes_out_stage.sv
// ----------------------------------------------------------------------------
// tes_out_stage: two-entry result buffer
// Parts the classifier from the output handshake; space flag is decoded from the registered count.
// ----------------------------------------------------------------------------
module tes_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  tes_pkg::result_t result,
  output logic             out_space,
  tes_out_if.source        out_ch
);
  import tes_pkg::*;

  localparam int          DEPTH = 2;
  localparam logic [1:0]  FULL  = 2'(DEPTH);

  kind_t      buf_r [DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_space          = cnt_r != FULL;
  assign out_ch.valid        = cnt_r != 2'd0;
  assign out_ch.encoding_kind = buf_r[rd_ptr_r];
  assign pop                = out_ch.valid && out_ch.ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (result.push) wr_ptr_nxt = ~wr_ptr_r;
    if (pop)         rd_ptr_nxt = ~rd_ptr_r;
    unique case ({result.push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.push) buf_r[wr_ptr_r] <= result.kind;
  end

endmodule

FILE: design/text_encoding_sniffer_top.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer_top: byte-stream encoding sniffer
// Byte-order-mark detection and lax UTF-8 check, one verdict per message.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                    | beat
//  in_ch   | in  | data_byte[7:0], byte_present, end_of_message | one byte
//  out_ch  | out | encoding_kind[2:0]                         | one verdict
//
//  One byte beat per clock while input ready is high; a closing beat passes through
//  the input register and then the two-entry result buffer on its way to the verdict.
//  Output stalls are absorbed by the buffer; input ready drops only when the
//  buffer is full and a closing beat is held.
//  Synchronous active-low reset clears all message state and both stages.
// ----------------------------------------------------------------------------
module text_encoding_sniffer_top (
  input  logic      clk,
  input  logic      rst_n,
  tes_in_if.sink    in_ch,
  tes_out_if.source out_ch
);
  import tes_pkg::*;

  stage_t  stage;
  result_t result;
  logic    take;
  logic    out_space;

  tes_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  tes_classify u_cls (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_space (out_space),
    .take      (take),
    .result    (result)
  );

  tes_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .out_space (out_space),
    .out_ch    (out_ch)
  );

endmodule

FILE: design/tes_checker.sv
// ----------------------------------------------------------------------------
// tes_checker: port-level checks for the sniffer
// Verdict bookkeeping against closing beats, legal codes, stall hold, idle after reset.
// ----------------------------------------------------------------------------
module tes_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_end_of_message,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_encoding_kind
);
  import tes_pkg::*;

  // closing beats taken whose verdict is not yet delivered
  logic [2:0] owed_r, owed_nxt;
  logic       in_close, out_beat;

  assign in_close = in_valid && in_ready && in_end_of_message;
  assign out_beat = out_valid && out_ready;

  always_comb begin
    owed_nxt = owed_r;
    if (in_close && !out_beat)      owed_nxt = owed_r + 3'd1;
    else if (!in_close && out_beat) owed_nxt = owed_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owed_r <= 3'd0;
    end else begin
      owed_r <= owed_nxt;
    end
  end

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r == 3'd0 |-> !out_valid)
    else $error("verdict without a closing beat");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    owed_r <= 3'd3)
    else $error("more verdicts in flight than the stages can hold");

  a_legal_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_encoding_kind <= 3'(KIND_UNKNOWN))
    else $error("illegal encoding_kind");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_encoding_kind))
    else $error("stalled verdict changed");

endmodule

bind text_encoding_sniffer_top tes_checker u_tes_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_end_of_message (in_ch.end_of_message),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_encoding_kind (out_ch.encoding_kind)
);
